>>> rtl/core/raycaster_sprite_projection_assert.svh
// Assertion macros shared by the RTL.
`ifndef RAYCASTER_SPRITE_PROJECTION_ASSERT_SVH
`define RAYCASTER_SPRITE_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
`define RSP_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rsp assertion failed");
`define RSP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("rsp assertion failed");
`else
`define RSP_ASSERT(label, prop)
`define RSP_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/core/rsp_pkg.sv
package rsp_pkg;

    localparam int RSP_SCREEN_WIDTH   = 1024;
    localparam int RSP_SCREEN_HEIGHT  = 768;
    localparam int RSP_VERT_DIVISOR   = 1;
    localparam int RSP_HORIZ_DIVISOR  = 1;

    localparam int POS_W   = 32;
    localparam int SX_W    = 33;
    localparam int VEC_W   = 16;
    localparam int PROD_W  = 49;
    localparam int NX_W    = 50;
    localparam int NMAG_W  = 49;
    localparam int DIR_FRAC = 14;
    localparam int DIV1_NW = NMAG_W + DIR_FRAC;
    localparam int DET_W   = 33;
    localparam int DMAG_W  = 32;
    localparam int TX_QW   = 48;
    localparam int A_W     = 50;
    localparam int SCR_QW  = 15;
    localparam int DEPTH_W = 32;
    localparam int DEPTH_MAG_W = 31;
    localparam int TAG_W   = 8;
    localparam int RECT_W  = 18;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 168;

    typedef enum logic [2:0] {
        REG_CAMERA_X   = 3'd0,
        REG_CAMERA_Y   = 3'd1,
        REG_DIR_X      = 3'd2,
        REG_DIR_Y      = 3'd3,
        REG_PLANE_X    = 3'd4,
        REG_PLANE_Y    = 3'd5,
        REG_VERT_OFFSET = 3'd6
    } rsp_reg_t;

    typedef struct packed {
        logic ovf;
        logic neg;
    } rsp_div_flag_t;

endpackage

>>> rtl/core/rsp_div.sv
module rsp_div
    import rsp_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 32,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_mag,
    input  logic [DW-1:0] den_mag,
    input  logic          neg_in,
    output logic [QW-1:0] quo_mag,
    output rsp_div_flag_t flag
);
    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [NW-1:0]  rem_reg  [QW];
    logic [DW-1:0]  den_reg  [QW];
    logic [QW-1:0]  quo_reg  [QW+1];
    rsp_div_flag_t  flag_reg [QW+1];

    // overflow: quotient does not fit in QW bits
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]      <= num_mag;
            den_reg[0]      <= den_mag;
            quo_reg[0]      <= '0;
            flag_reg[0].ovf <= CW'(num_mag) >= (CW'(den_mag) << QW);
            flag_reg[0].neg <= neg_in;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [CW-1:0] trial;
        logic          take;

        assign trial = CW'(den_reg[k-1]) << (QW - k);
        assign take  = CW'(rem_reg[k-1]) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k]  <= take ? (quo_reg[k-1] | (QW'(1) << (QW - k))) : quo_reg[k-1];
                flag_reg[k] <= flag_reg[k-1];
            end
        end

        if (k < QW) begin : g_carry
            logic [CW-1:0] rem_next;
            assign rem_next = CW'(rem_reg[k-1]) - trial;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? rem_next[NW-1:0] : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo_mag = quo_reg[QW];
    assign flag    = flag_reg[QW];

endmodule

>>> rtl/core/raycaster_sprite_projection.sv
// Channel   Dir  Width  Contents
// s_axis    in   72     sprite_tag, sprite_pos_x, sprite_pos_y
// m_axis    out  168    result_tag, visible, depth, centre_column, vertical_shift,
//                       sprite_height, sprite_width, first_column, last_column,
//                       first_row, last_row
// cfg       in   3+32   register index, write data
//
// One sprite per cycle while m_axis is not stalled, through the 48-step and
// 15-step restoring divider pipelines. Reset is synchronous and resets valid bits
// and configuration registers only. A stalled m_axis freezes the pipeline; the input
// stage still takes a beat while it is empty. cfg is always ready.
`include "raycaster_sprite_projection_assert.svh"

module raycaster_sprite_projection
    import rsp_pkg::*;
#(
    parameter int SCREEN_WIDTH   = RSP_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT  = RSP_SCREEN_HEIGHT,
    parameter int VERT_DIVISOR   = RSP_VERT_DIVISOR,
    parameter int HORIZ_DIVISOR  = RSP_HORIZ_DIVISOR
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // sprite_tag, sprite_pos_x, sprite_pos_y
    output logic             m_tvalid,
    input  logic             m_tready,
    // result_tag, visible, depth, centre_column, vertical_shift, sprite_height,
    // sprite_width, first_column, last_column, first_row, last_row, zero pad
    output logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data
);
    localparam int HALF    = SCREEN_WIDTH / 2;
    localparam int HALF_W  = $clog2(HALF + 1);
    localparam int CN_W    = A_W + HALF_W;
    localparam int HN_W    = $clog2(SCREEN_HEIGHT + 1) + 16;
    localparam int VDEN_W  = DEPTH_MAG_W + $clog2(VERT_DIVISOR + 1);
    localparam int HDEN_W  = DEPTH_MAG_W + $clog2(HORIZ_DIVISOR + 1);
    localparam int L1      = TX_QW + 1;
    localparam int L2      = SCR_QW + 1;
    localparam logic [HN_W-1:0] HEIGHT_NUM = HN_W'(SCREEN_HEIGHT) << 16;
    localparam logic signed [RECT_W-1:0] SH_HALF = RECT_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [RECT_W-1:0] SH_MAX  = RECT_W'(SCREEN_HEIGHT - 1);
    localparam logic signed [RECT_W-1:0] SW_MAX  = RECT_W'(SCREEN_WIDTH - 1);
    localparam logic signed [RECT_W-1:0] POS_MAX = RECT_W'(32767);
    localparam logic signed [RECT_W-1:0] NEG_MIN = -RECT_W'(32768);

    // configuration
    logic signed [POS_W-1:0] camera_x_reg, camera_y_reg, vert_offset_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic signed [31:0]      det_p1_reg, det_p2_reg;
    logic signed [DET_W-1:0] det_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg    <= '0;
            camera_y_reg    <= '0;
            dir_x_reg       <= 16'sd16384;
            dir_y_reg       <= '0;
            plane_x_reg     <= '0;
            plane_y_reg     <= 16'sd10813;
            vert_offset_reg <= '0;
        end else if (cfg_valid) begin
            unique case (rsp_reg_t'(cfg_index))
                REG_CAMERA_X:    camera_x_reg    <= cfg_data;
                REG_CAMERA_Y:    camera_y_reg    <= cfg_data;
                REG_DIR_X:       dir_x_reg       <= cfg_data[VEC_W-1:0];
                REG_DIR_Y:       dir_y_reg       <= cfg_data[VEC_W-1:0];
                REG_PLANE_X:     plane_x_reg     <= cfg_data[VEC_W-1:0];
                REG_PLANE_Y:     plane_y_reg     <= cfg_data[VEC_W-1:0];
                REG_VERT_OFFSET: vert_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        det_p1_reg <= 32'(plane_x_reg) * 32'(dir_y_reg);
        det_p2_reg <= 32'(dir_x_reg) * 32'(plane_y_reg);
        det_reg    <= DET_W'(det_p1_reg) - DET_W'(det_p2_reg);
    end

    // pipeline control
    logic adv, en_a;
    logic m_valid_reg;
    logic a_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign en_a     = adv || !a_valid_reg;
    assign s_tready = en_a;

    // stage A: offsets
    logic signed [POS_W-1:0] in_pos_x, in_pos_y;
    logic [TAG_W-1:0]        a_tag_reg;
    logic signed [SX_W-1:0]  a_sx_reg, a_sy_reg;

    assign in_pos_x = s_tdata[39:8];
    assign in_pos_y = s_tdata[71:40];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en_a) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_tag_reg <= s_tdata[7:0];
            a_sx_reg  <= SX_W'(in_pos_x) - SX_W'(camera_x_reg);
            a_sy_reg  <= SX_W'(in_pos_y) - SX_W'(camera_y_reg);
        end
    end

    // stage B: products
    logic                     b_valid_reg;
    logic [TAG_W-1:0]         b_tag_reg;
    logic signed [PROD_W-1:0] b_p1_reg, b_p2_reg, b_p3_reg, b_p4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_tag_reg <= a_tag_reg;
            b_p1_reg  <= PROD_W'(dir_y_reg) * PROD_W'(a_sx_reg);
            b_p2_reg  <= PROD_W'(dir_x_reg) * PROD_W'(a_sy_reg);
            b_p3_reg  <= PROD_W'(plane_x_reg) * PROD_W'(a_sy_reg);
            b_p4_reg  <= PROD_W'(plane_y_reg) * PROD_W'(a_sx_reg);
        end
    end

    // stage C: numerators to sign and magnitude
    logic signed [NX_W-1:0] c_nx_next, c_ny_next;
    logic [NX_W-1:0]        c_nx_abs, c_ny_abs;
    logic [DET_W-1:0]       c_det_abs;
    logic                   c_valid_reg, c_det_zero_reg;
    logic [TAG_W-1:0]       c_tag_reg;
    logic                   c_nx_neg_reg, c_ny_neg_reg, c_det_neg_reg;
    logic [NMAG_W-1:0]      c_nx_mag_reg, c_ny_mag_reg;
    logic [DMAG_W-1:0]      c_det_mag_reg;

    assign c_nx_next = NX_W'(b_p1_reg) - NX_W'(b_p2_reg);
    assign c_ny_next = NX_W'(b_p3_reg) - NX_W'(b_p4_reg);
    assign c_nx_abs  = c_nx_next[NX_W-1] ? -c_nx_next : c_nx_next;
    assign c_ny_abs  = c_ny_next[NX_W-1] ? -c_ny_next : c_ny_next;
    assign c_det_abs = det_reg[DET_W-1] ? -det_reg : det_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_tag_reg      <= b_tag_reg;
            c_nx_neg_reg   <= c_nx_next[NX_W-1];
            c_ny_neg_reg   <= c_ny_next[NX_W-1];
            c_nx_mag_reg   <= c_nx_abs[NMAG_W-1:0];
            c_ny_mag_reg   <= c_ny_abs[NMAG_W-1:0];
            c_det_neg_reg  <= det_reg[DET_W-1];
            c_det_mag_reg  <= c_det_abs[DMAG_W-1:0];
            c_det_zero_reg <= det_reg == '0;
        end
    end

    // camera-space dividers
    logic [TX_QW-1:0] tx_quo, dp_quo;
    rsp_div_flag_t    tx_flag, dp_flag;

    rsp_div #(.NW(DIV1_NW), .DW(DMAG_W), .QW(TX_QW)) u_div_tx (
        .aclk    (aclk),
        .en      (adv),
        .num_mag ({c_nx_mag_reg, DIR_FRAC'(0)}),
        .den_mag (c_det_mag_reg),
        .neg_in  (c_nx_neg_reg ^ c_det_neg_reg),
        .quo_mag (tx_quo),
        .flag    (tx_flag)
    );

    rsp_div #(.NW(DIV1_NW), .DW(DMAG_W), .QW(TX_QW)) u_div_depth (
        .aclk    (aclk),
        .en      (adv),
        .num_mag ({c_ny_mag_reg, DIR_FRAC'(0)}),
        .den_mag (c_det_mag_reg),
        .neg_in  (c_ny_neg_reg ^ c_det_neg_reg),
        .quo_mag (dp_quo),
        .flag    (dp_flag)
    );

    logic             s1_valid_reg [L1];
    logic [TAG_W-1:0] s1_tag_reg   [L1];
    logic             s1_dz_reg    [L1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L1; i++) s1_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            s1_valid_reg[0] <= c_valid_reg;
            for (int i = 1; i < L1; i++) s1_valid_reg[i] <= s1_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg[0] <= c_tag_reg;
            s1_dz_reg[0]  <= c_det_zero_reg;
            for (int i = 1; i < L1; i++) begin
                s1_tag_reg[i] <= s1_tag_reg[i-1];
                s1_dz_reg[i]  <= s1_dz_reg[i-1];
            end
        end
    end

    // stage D: depth, tx, depth + tx
    logic [TX_QW:0]            tx_mag;
    logic signed [A_W-1:0]     tx_val, a_val;
    logic [A_W-1:0]            a_abs;
    logic signed [DEPTH_W-1:0] depth_sat, depth_next;
    logic                      dp_big, vis_next;
    logic                      d_valid_reg, d_vis_reg, d_a_neg_reg;
    logic [TAG_W-1:0]          d_tag_reg;
    logic signed [DEPTH_W-1:0] d_depth_reg;
    logic [A_W-1:0]            d_a_mag_reg;

    assign tx_mag = tx_flag.ovf ? {1'b1, TX_QW'(0)} : {1'b0, tx_quo};
    assign tx_val = tx_flag.neg ? -A_W'(tx_mag) : A_W'(tx_mag);
    assign dp_big = dp_flag.ovf || (dp_quo[TX_QW-1:DEPTH_MAG_W] != '0);

    always_comb begin
        if (dp_big) begin
            depth_sat = dp_flag.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (dp_flag.neg) begin
            depth_sat = -DEPTH_W'(dp_quo[DEPTH_MAG_W-1:0]);
        end else begin
            depth_sat = DEPTH_W'(dp_quo[DEPTH_MAG_W-1:0]);
        end
    end

    assign depth_next = s1_dz_reg[L1-1] ? '0 : depth_sat;
    assign vis_next   = !s1_dz_reg[L1-1] && !depth_next[DEPTH_W-1] && depth_next != '0;
    assign a_val      = A_W'(depth_next) + tx_val;
    assign a_abs      = a_val[A_W-1] ? -a_val : a_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= s1_valid_reg[L1-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_tag_reg   <= s1_tag_reg[L1-1];
            d_vis_reg   <= vis_next;
            d_depth_reg <= depth_next;
            d_a_neg_reg <= a_val[A_W-1];
            d_a_mag_reg <= a_abs;
        end
    end

    // stage E: scaled numerators and divisors
    logic [POS_W:0]             vo_abs;
    logic                       e_valid_reg, e_vis_reg, e_cen_neg_reg, e_sh_neg_reg;
    logic [TAG_W-1:0]           e_tag_reg;
    logic signed [DEPTH_W-1:0]  e_depth_reg;
    logic [CN_W-1:0]            e_cen_num_reg;
    logic [POS_W-1:0]           e_sh_num_reg;
    logic [DEPTH_MAG_W-1:0]     e_dmag_reg;
    logic [VDEN_W-1:0]          e_vden_reg;
    logic [HDEN_W-1:0]          e_hden_reg;

    assign vo_abs = vert_offset_reg[POS_W-1] ? -(POS_W+1)'(vert_offset_reg)
                                             : (POS_W+1)'(vert_offset_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_tag_reg     <= d_tag_reg;
            e_vis_reg     <= d_vis_reg;
            e_depth_reg   <= d_depth_reg;
            e_cen_neg_reg <= d_a_neg_reg;
            e_cen_num_reg <= CN_W'(d_a_mag_reg) * CN_W'(HALF);
            e_sh_neg_reg  <= vert_offset_reg[POS_W-1];
            e_sh_num_reg  <= vo_abs[POS_W-1:0];
            e_dmag_reg    <= d_depth_reg[DEPTH_MAG_W-1:0];
            e_vden_reg    <= VDEN_W'(d_depth_reg[DEPTH_MAG_W-1:0]) * VDEN_W'(VERT_DIVISOR);
            e_hden_reg    <= HDEN_W'(d_depth_reg[DEPTH_MAG_W-1:0]) * HDEN_W'(HORIZ_DIVISOR);
        end
    end

    // screen dividers
    logic [SCR_QW-1:0] cen_quo, sh_quo, ht_quo, wd_quo;
    rsp_div_flag_t     cen_flag, sh_flag, ht_flag, wd_flag;

    rsp_div #(.NW(CN_W), .DW(DEPTH_MAG_W), .QW(SCR_QW)) u_div_centre (
        .aclk (aclk), .en (adv), .num_mag (e_cen_num_reg), .den_mag (e_dmag_reg),
        .neg_in (e_cen_neg_reg), .quo_mag (cen_quo), .flag (cen_flag)
    );

    rsp_div #(.NW(POS_W), .DW(DEPTH_MAG_W), .QW(SCR_QW)) u_div_shift (
        .aclk (aclk), .en (adv), .num_mag (e_sh_num_reg), .den_mag (e_dmag_reg),
        .neg_in (e_sh_neg_reg), .quo_mag (sh_quo), .flag (sh_flag)
    );

    rsp_div #(.NW(HN_W), .DW(VDEN_W), .QW(SCR_QW)) u_div_height (
        .aclk (aclk), .en (adv), .num_mag (HEIGHT_NUM), .den_mag (e_vden_reg),
        .neg_in (1'b0), .quo_mag (ht_quo), .flag (ht_flag)
    );

    rsp_div #(.NW(HN_W), .DW(HDEN_W), .QW(SCR_QW)) u_div_width (
        .aclk (aclk), .en (adv), .num_mag (HEIGHT_NUM), .den_mag (e_hden_reg),
        .neg_in (1'b0), .quo_mag (wd_quo), .flag (wd_flag)
    );

    logic                      s2_valid_reg [L2];
    logic [TAG_W-1:0]          s2_tag_reg   [L2];
    logic                      s2_vis_reg   [L2];
    logic signed [DEPTH_W-1:0] s2_depth_reg [L2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L2; i++) s2_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            s2_valid_reg[0] <= e_valid_reg;
            for (int i = 1; i < L2; i++) s2_valid_reg[i] <= s2_valid_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_tag_reg[0]   <= e_tag_reg;
            s2_vis_reg[0]   <= e_vis_reg;
            s2_depth_reg[0] <= e_depth_reg;
            for (int i = 1; i < L2; i++) begin
                s2_tag_reg[i]   <= s2_tag_reg[i-1];
                s2_vis_reg[i]   <= s2_vis_reg[i-1];
                s2_depth_reg[i] <= s2_depth_reg[i-1];
            end
        end
    end

    // stage F: saturation of divider results to output field widths
    logic signed [15:0]        cen_next, sh_next;
    logic                      f_valid_reg, f_vis_reg;
    logic [TAG_W-1:0]          f_tag_reg;
    logic signed [DEPTH_W-1:0] f_depth_reg;
    logic signed [15:0]        f_centre_reg, f_shift_reg;
    logic [SCR_QW-1:0]         f_height_reg, f_width_reg;

    always_comb begin
        if (cen_flag.ovf) begin
            cen_next = cen_flag.neg ? 16'sh8000 : 16'sh7fff;
        end else begin
            cen_next = cen_flag.neg ? -16'(cen_quo) : 16'(cen_quo);
        end
        if (sh_flag.ovf) begin
            sh_next = sh_flag.neg ? 16'sh8000 : 16'sh7fff;
        end else begin
            sh_next = sh_flag.neg ? -16'(sh_quo) : 16'(sh_quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= s2_valid_reg[L2-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_tag_reg    <= s2_tag_reg[L2-1];
            f_vis_reg    <= s2_vis_reg[L2-1];
            f_depth_reg  <= s2_depth_reg[L2-1];
            f_centre_reg <= cen_next;
            f_shift_reg  <= sh_next;
            f_height_reg <= ht_flag.ovf ? '1 : ht_quo;
            f_width_reg  <= wd_flag.ovf ? '1 : wd_quo;
        end
    end

    // output stage: screen rectangle
    logic signed [RECT_W-1:0] shift_x, centre_x, h_half, w_half;
    logic signed [RECT_W-1:0] fr_sum, lr_sum, fc_sum, lc_sum;
    logic [14:0]              fr_next, fc_next;
    logic [15:0]              lr_next, lc_next;

    assign shift_x  = RECT_W'(f_shift_reg);
    assign centre_x = RECT_W'(f_centre_reg);
    assign h_half   = RECT_W'(f_height_reg >> 1);
    assign w_half   = RECT_W'(f_width_reg >> 1);
    assign fr_sum   = SH_HALF + shift_x - h_half;
    assign lr_sum   = SH_HALF + shift_x + h_half;
    assign fc_sum   = centre_x - w_half;
    assign lc_sum   = centre_x + w_half;

    always_comb begin
        fr_next = (fr_sum < 0) ? '0 : ((fr_sum > POS_MAX) ? 15'h7fff : fr_sum[14:0]);
        fc_next = (fc_sum < 0) ? '0 : ((fc_sum > POS_MAX) ? 15'h7fff : fc_sum[14:0]);
        lr_next = (lr_sum < NEG_MIN) ? 16'h8000
                : ((lr_sum > SH_MAX) ? SH_MAX[15:0] : lr_sum[15:0]);
        lc_next = (lc_sum < NEG_MIN) ? 16'h8000
                : ((lc_sum > SW_MAX) ? SW_MAX[15:0] : lc_sum[15:0]);
    end

    logic [TAG_W-1:0]   m_tag_reg;
    logic               m_vis_reg;
    logic [DEPTH_W-1:0] m_depth_reg;
    logic [15:0]        m_centre_reg, m_shift_reg, m_lc_reg, m_lr_reg;
    logic [14:0]        m_height_reg, m_width_reg, m_fc_reg, m_fr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tag_reg    <= f_tag_reg;
            m_vis_reg    <= f_vis_reg;
            m_depth_reg  <= f_depth_reg;
            m_centre_reg <= f_vis_reg ? f_centre_reg : '0;
            m_shift_reg  <= f_vis_reg ? f_shift_reg : '0;
            m_height_reg <= f_vis_reg ? f_height_reg : '0;
            m_width_reg  <= f_vis_reg ? f_width_reg : '0;
            m_fc_reg     <= f_vis_reg ? fc_next : '0;
            m_lc_reg     <= f_vis_reg ? lc_next : '0;
            m_fr_reg     <= f_vis_reg ? fr_next : '0;
            m_lr_reg     <= f_vis_reg ? lr_next : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_lr_reg, m_fr_reg, m_lc_reg, m_fc_reg, m_width_reg,
                       m_height_reg, m_shift_reg, m_centre_reg, m_depth_reg,
                       m_vis_reg, m_tag_reg};

    `RSP_ASSERT(a_hidden_zero, m_valid_reg && !m_vis_reg |-> m_centre_reg == '0 && m_height_reg == '0 && m_lr_reg == '0)
    `RSP_ASSERT(a_vis_depth, m_valid_reg && m_vis_reg |-> !m_depth_reg[DEPTH_W-1] && m_depth_reg != '0)
    `RSP_ASSERT(a_row_bound, m_valid_reg && m_vis_reg |-> $signed(m_lr_reg) <= $signed(SH_MAX[15:0]))
    `RSP_ASSERT(a_take_input, s_tvalid && s_tready |=> a_valid_reg)

endmodule
